// File: hdl/lctm_pkg.sv
// Shared constants, codes and types of the load-cell trimmed-mean autorange unit.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package lctm_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int WINDOW       = 5;

   localparam int CAL_W       = 24;
   localparam int SPAN_W      = 26;
   localparam int CTR_W       = 26;
   localparam int LEVEL_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 26;

   // trimmed sum and divide by WINDOW-2 through a reciprocal multiply
   localparam int TRIM_DIV  = WINDOW - 2;
   localparam int SUM_W     = SAMPLE_WIDTH + $clog2(WINDOW);
   localparam int MAG_W     = SUM_W - 1;
   localparam int DIV_SHIFT = MAG_W + $clog2(TRIM_DIV) + 1;
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam logic [MULT_W-1:0] DIV_ONE  = MULT_W'(1) << DIV_SHIFT;
   localparam logic [MULT_W-1:0] DIV_MULT =
      (DIV_ONE + MULT_W'(TRIM_DIV - 1)) / MULT_W'(TRIM_DIV);
   localparam int PROD_W = MAG_W + MULT_W;

   // centering arithmetic
   localparam int DIFF_W = ((SAMPLE_WIDTH > CAL_W) ? SAMPLE_WIDTH : CAL_W) + 1;
   localparam int WIDE_W = ((DIFF_W > CTR_W) ? DIFF_W : CTR_W) + 1;
   localparam int GROW_W = CTR_W + 1;
   localparam int LVL_W  = CTR_W + 4;

   localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
   localparam logic [SPAN_W-1:0] SPAN_MIN = SPAN_W'(1);

   localparam logic signed [CAL_W-1:0] CAL_OFFSET_RESET     = CAL_W'(2638);
   localparam logic [SPAN_W-1:0]       INITIAL_RANGE_RESET  = SPAN_W'(4361);
   localparam logic [SPAN_W-1:0]       BALANCED_RANGE_RESET = SPAN_W'(218);

   // alarm thresholds as fractions of the span: WARN_NUM/LEVEL_DEN, ALARM_NUM/LEVEL_DEN
   localparam int LEVEL_DEN = 10;
   localparam int WARN_NUM  = 3;
   localparam int ALARM_NUM = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_CALIBRATION_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_RANGE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCED_RANGE     = 2'd2;

   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_BALANCE = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_NORMAL  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_WARNING = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_ALARM   = 2'd2;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef sample_type window_type [WINDOW];

endpackage

`default_nettype wire

// File: hdl/load_cell_trimmed_mean_autorange_unit.sv
// Load-cell front end: five-sample trimmed mean, offset centering, auto-range, alarm level.
// Depends on lctm_pkg for widths, reset values, register indexes and codes.
`default_nettype none

// A beat is accepted every cycle unless a result is held under rsp_stall; it passes
// through the seven stages plus the result register. Throughput is one beat per cycle
// while no result is stalled, set by the feedback loops of the balance offset (stage six)
// and the range register (stage seven). A stall on the result side freezes the whole
// pipeline, so req_stall is high exactly while a result is held under rsp_stall. The
// sample window shifts when a push beat is accepted; a balance beat leaves it alone.
// initial_range is loaded into the range only by reset, and reset also restores its
// default, so a write to that register has no visible effect.
module load_cell_trimmed_mean_autorange_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_command,
   input  logic signed [lctm_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [lctm_pkg::CTR_W-1:0]        rsp_mean_centered,
   output logic signed [lctm_pkg::CTR_W-1:0]        rsp_latest_centered,
   output logic        [lctm_pkg::SPAN_W-1:0]       rsp_range_span,
   output logic        [lctm_pkg::LEVEL_W-1:0]      rsp_level,
   input  logic                                     csr_write,
   input  logic        [lctm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic        [lctm_pkg::CSR_DATA_W-1:0]   csr_data
);

   function automatic logic signed [lctm_pkg::CTR_W-1:0] sat_ctr(
      input logic signed [lctm_pkg::WIDE_W-1:0] v);
      logic top_ones;
      logic top_zeros;
      top_ones  = &v[lctm_pkg::WIDE_W-1:lctm_pkg::CTR_W-1];
      top_zeros = ~|v[lctm_pkg::WIDE_W-1:lctm_pkg::CTR_W-1];
      if (top_ones || top_zeros) begin
         sat_ctr = v[lctm_pkg::CTR_W-1:0];
      end else if (v[lctm_pkg::WIDE_W-1]) begin
         sat_ctr = {1'b1, {(lctm_pkg::CTR_W-1){1'b0}}};
      end else begin
         sat_ctr = {1'b0, {(lctm_pkg::CTR_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [lctm_pkg::CTR_W-1:0] mag_ctr(
      input logic signed [lctm_pkg::CTR_W-1:0] v);
      logic signed [lctm_pkg::CTR_W:0] e;
      e = (lctm_pkg::CTR_W+1)'(v);
      if (v[lctm_pkg::CTR_W-1]) begin
         e = -e;
      end
      mag_ctr = e[lctm_pkg::CTR_W-1:0];
   endfunction

   logic advance;
   logic accept;

   // configuration
   logic signed [lctm_pkg::CAL_W-1:0] cal_ff;
   logic        [lctm_pkg::SPAN_W-1:0] bal_span_ff;
   logic        [lctm_pkg::SPAN_W-1:0] bal_load;

   // window
   lctm_pkg::window_type window_ff;
   lctm_pkg::window_type window_in;

   // stage 1: window snapshot
   logic                 st1_valid_ff;
   logic                 st1_bal_ff;
   lctm_pkg::window_type st1_win_ff;

   // stage 2: sum, min, max
   logic                                    st2_valid_ff;
   logic                                    st2_bal_ff;
   logic signed [lctm_pkg::SUM_W-1:0]       st2_sum_ff;
   logic signed [lctm_pkg::SUM_W-1:0]       sum_in;
   lctm_pkg::sample_type                    st2_lo_ff;
   lctm_pkg::sample_type                    st2_hi_ff;
   lctm_pkg::sample_type                    lo_in;
   lctm_pkg::sample_type                    hi_in;
   lctm_pkg::sample_type                    st2_latest_ff;

   // stage 3: trimmed sum magnitude
   logic                                    st3_valid_ff;
   logic                                    st3_bal_ff;
   logic                                    st3_neg_ff;
   logic        [lctm_pkg::MAG_W-1:0]       st3_mag_ff;
   logic        [lctm_pkg::MAG_W-1:0]       mag_in;
   logic signed [lctm_pkg::SUM_W-1:0]       trim;
   logic signed [lctm_pkg::SUM_W-1:0]       trim_neg;
   lctm_pkg::sample_type                    st3_latest_ff;

   // stage 4: quotient
   logic                                    st4_valid_ff;
   logic                                    st4_bal_ff;
   logic                                    st4_neg_ff;
   logic        [lctm_pkg::PROD_W-1:0]      prod;
   logic        [lctm_pkg::SAMPLE_WIDTH-1:0] st4_q_ff;
   lctm_pkg::sample_type                    st4_latest_ff;

   // stage 5: less calibration
   logic                                    st5_valid_ff;
   logic                                    st5_bal_ff;
   logic        [lctm_pkg::SAMPLE_WIDTH-1:0] q_neg;
   lctm_pkg::sample_type                    mean;
   logic signed [lctm_pkg::DIFF_W-1:0]      st5_d_ff;
   logic signed [lctm_pkg::DIFF_W-1:0]      st5_dl_ff;

   // stage 6: centered values, balance offset
   logic                                    st6_valid_ff;
   logic                                    st6_bal_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       st6_mean_c_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       st6_latest_c_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       bal_off_ff;

   // stage 7: range update
   logic                                    st7_valid_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       st7_mean_c_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       st7_latest_c_ff;
   logic        [lctm_pkg::CTR_W-1:0]       st7_lat_mag_ff;
   logic        [lctm_pkg::SPAN_W-1:0]      range_ff;
   logic        [lctm_pkg::SPAN_W-1:0]      range_in;
   logic        [lctm_pkg::SPAN_W-1:0]      range_base;
   logic        [lctm_pkg::GROW_W-1:0]      grow;

   // result
   logic                                    rsp_valid_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       rsp_mean_ff;
   logic signed [lctm_pkg::CTR_W-1:0]       rsp_latest_ff;
   logic        [lctm_pkg::SPAN_W-1:0]      rsp_range_ff;
   logic        [lctm_pkg::LEVEL_W-1:0]     rsp_level_ff;
   logic        [lctm_pkg::LEVEL_W-1:0]     level_in;
   logic        [lctm_pkg::LVL_W-1:0]       lat_scaled;
   logic        [lctm_pkg::LVL_W-1:0]       warn_limit;
   logic        [lctm_pkg::LVL_W-1:0]       alarm_limit;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff      <= lctm_pkg::CAL_OFFSET_RESET;
         bal_span_ff <= lctm_pkg::BALANCED_RANGE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lctm_pkg::CSR_CALIBRATION_OFFSET: begin
               cal_ff <= csr_data[lctm_pkg::CAL_W-1:0];
            end
            lctm_pkg::CSR_BALANCED_RANGE: begin
               bal_span_ff <= csr_data[lctm_pkg::SPAN_W-1:0];
            end
            lctm_pkg::CSR_INITIAL_RANGE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign bal_load = (bal_span_ff == '0) ? lctm_pkg::SPAN_MIN : bal_span_ff;

   // ---------------- window ----------------
   always_comb begin
      window_in = window_ff;
      if (accept && req_command == lctm_pkg::CMD_PUSH) begin
         for (int i = lctm_pkg::WINDOW - 1; i > 0; i--) begin
            window_in[i] = window_ff[i-1];
         end
         window_in[0] = req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lctm_pkg::WINDOW; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------- datapath combinational ----------------
   always_comb begin
      sum_in = lctm_pkg::SUM_W'(st1_win_ff[0]);
      lo_in  = st1_win_ff[0];
      hi_in  = st1_win_ff[0];
      for (int i = 1; i < lctm_pkg::WINDOW; i++) begin
         sum_in = sum_in + lctm_pkg::SUM_W'(st1_win_ff[i]);
         if (st1_win_ff[i] < lo_in) begin
            lo_in = st1_win_ff[i];
         end
         if (st1_win_ff[i] > hi_in) begin
            hi_in = st1_win_ff[i];
         end
      end
   end

   assign trim     = st2_sum_ff - lctm_pkg::SUM_W'(st2_lo_ff) - lctm_pkg::SUM_W'(st2_hi_ff);
   assign trim_neg = -trim;
   assign mag_in   = trim[lctm_pkg::SUM_W-1] ? trim_neg[lctm_pkg::MAG_W-1:0]
                                             : trim[lctm_pkg::MAG_W-1:0];

   assign prod = lctm_pkg::PROD_W'(st3_mag_ff) * lctm_pkg::PROD_W'(lctm_pkg::DIV_MULT);

   assign q_neg = -st4_q_ff;
   assign mean  = st4_neg_ff ? $signed(q_neg) : $signed(st4_q_ff);

   always_comb begin
      range_base = st6_bal_ff ? bal_load : range_ff;
      grow       = {mag_ctr(st6_mean_c_ff), 1'b0};
      range_in   = range_base;
      if (grow > lctm_pkg::GROW_W'(range_base)) begin
         if (grow > lctm_pkg::GROW_W'(lctm_pkg::SPAN_MAX)) begin
            range_in = lctm_pkg::SPAN_MAX;
         end else begin
            range_in = grow[lctm_pkg::SPAN_W-1:0];
         end
      end
   end

   assign lat_scaled  = lctm_pkg::LVL_W'(st7_lat_mag_ff) * lctm_pkg::LVL_W'(lctm_pkg::LEVEL_DEN);
   assign warn_limit  = lctm_pkg::LVL_W'(range_ff) * lctm_pkg::LVL_W'(lctm_pkg::WARN_NUM);
   assign alarm_limit = lctm_pkg::LVL_W'(range_ff) * lctm_pkg::LVL_W'(lctm_pkg::ALARM_NUM);

   always_comb begin
      if (lat_scaled > alarm_limit) begin
         level_in = lctm_pkg::LEVEL_ALARM;
      end else if (lat_scaled > warn_limit) begin
         level_in = lctm_pkg::LEVEL_WARNING;
      end else begin
         level_in = lctm_pkg::LEVEL_NORMAL;
      end
   end

   // ---------------- pipeline control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
         st6_valid_ff <= 1'b0;
         st7_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         st5_valid_ff <= st4_valid_ff;
         st6_valid_ff <= st5_valid_ff;
         st7_valid_ff <= st6_valid_ff;
         rsp_valid_ff <= st7_valid_ff;
      end
   end

   // ---------------- pipeline payload ----------------
   always_ff @(posedge clock) begin
      if (advance) begin
         st1_bal_ff      <= (req_command == lctm_pkg::CMD_BALANCE);
         st1_win_ff      <= window_in;

         st2_bal_ff      <= st1_bal_ff;
         st2_sum_ff      <= sum_in;
         st2_lo_ff       <= lo_in;
         st2_hi_ff       <= hi_in;
         st2_latest_ff   <= st1_win_ff[0];

         st3_bal_ff      <= st2_bal_ff;
         st3_neg_ff      <= trim[lctm_pkg::SUM_W-1];
         st3_mag_ff      <= mag_in;
         st3_latest_ff   <= st2_latest_ff;

         st4_bal_ff      <= st3_bal_ff;
         st4_neg_ff      <= st3_neg_ff;
         st4_q_ff        <= prod[lctm_pkg::DIV_SHIFT +: lctm_pkg::SAMPLE_WIDTH];
         st4_latest_ff   <= st3_latest_ff;

         st5_bal_ff      <= st4_bal_ff;
         st5_d_ff        <= lctm_pkg::DIFF_W'(mean) - lctm_pkg::DIFF_W'(cal_ff);
         st5_dl_ff       <= lctm_pkg::DIFF_W'(st4_latest_ff) - lctm_pkg::DIFF_W'(cal_ff);

         st6_bal_ff      <= st5_bal_ff;
         st6_mean_c_ff   <= sat_ctr(lctm_pkg::WIDE_W'(st5_d_ff)
                                    - lctm_pkg::WIDE_W'(bal_off_ff));
         st6_latest_c_ff <= sat_ctr(lctm_pkg::WIDE_W'(st5_dl_ff)
                                    - lctm_pkg::WIDE_W'(bal_off_ff));

         st7_mean_c_ff   <= st6_mean_c_ff;
         st7_latest_c_ff <= st6_latest_c_ff;
         st7_lat_mag_ff  <= mag_ctr(st6_latest_c_ff);

         rsp_mean_ff     <= st7_mean_c_ff;
         rsp_latest_ff   <= st7_latest_c_ff;
         rsp_range_ff    <= range_ff;
         rsp_level_ff    <= level_in;
      end
   end

   // ---------------- feedback state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bal_off_ff <= '0;
      end else if (advance && st5_valid_ff && st5_bal_ff) begin
         bal_off_ff <= sat_ctr(lctm_pkg::WIDE_W'(st5_d_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= lctm_pkg::INITIAL_RANGE_RESET;
      end else if (advance && st6_valid_ff) begin
         range_ff <= range_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_centered   = rsp_mean_ff;
   assign rsp_latest_centered = rsp_latest_ff;
   assign rsp_range_span      = rsp_range_ff;
   assign rsp_level           = rsp_level_ff;

   // ---------------- assertions ----------------
   a_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      range_ff != '0)
      else $error("range register reached zero");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({st1_valid_ff, st2_valid_ff, st3_valid_ff, st4_valid_ff,
                            st5_valid_ff, st6_valid_ff, st7_valid_ff}))
      else $error("pipeline moved while result was stalled");

   a_balance_span: assert property (@(posedge clock) disable iff (reset)
      (advance && st6_valid_ff && st6_bal_ff) |=> (range_ff >= $past(bal_load)))
      else $error("balance left range below balanced span");

endmodule

`default_nettype wire
